/* rtl/rmet_pkg.sv */
// rmet_pkg: shared types, constants and helpers for the rssi tracker
// no dependencies
`timescale 1ns / 1ps
package rmet_pkg;
	localparam int WINDOW_SIZE_DEF = 7;
	localparam logic signed [15:0] LEVEL_FLOOR = -16'sd32512;
	localparam logic signed [7:0] RAW_FLOOR = -8'sd127;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_PEAK   = 2'd1,
		KIND_QUERY  = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_SEARCHING = 3'd0,
		ST_LOST      = 3'd1,
		ST_WARMER    = 3'd2,
		ST_COLDER    = 3'd3,
		ST_STEADY    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		REG_ADDR   = 3'd0,
		REG_LOST   = 3'd1,
		REG_THRESH = 3'd2,
		REG_FAST   = 3'd3,
		REG_STABLE = 3'd4,
		REG_JITTER = 3'd5,
		REG_BAR    = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WRITE,
		S_SORT,
		S_MEDIAN,
		S_FAST,
		S_SLOW,
		S_JIT,
		S_JIT2,
		S_SNAP,
		S_SNAP2,
		S_OUT
	} state_t;

	typedef struct packed {
		logic start;     // latch item, decide kind
		logic win_write; // push rssi into window
		logic sort_step; // one compare pass over the window
		logic med;       // compute median
		logic seed;
		logic upd_fast;
		logic upd_slow;
		logic upd_jit;
		logic fin_jit;
		logic peak_reset;
		logic clear;
		logic snap;
		logic snap2;
	} cmd_t;

	typedef struct packed {
		logic is_sample_match;
		logic is_peak;
		logic is_clear;
		logic seeded;
		logic sort_done;
	} stat_t;

	typedef struct packed {
		logic [31:0] lost_timeout;
		logic [14:0] threshold;
		logic [15:0] alpha_fast;
		logic [15:0] alpha_slow;
		logic [15:0] alpha_jit;
		logic [9:0]  bar_width;
	} cfg_t;

	// round(alpha*diff/65536), half up; diff fits 18 bits signed
	function automatic logic signed [19:0] ema_step(input logic signed [17:0] diff,
			input logic [15:0] alpha);
		logic signed [35:0] p;
		begin
			p = $signed({1'b0, alpha}) * diff + 36'sd32768;
			ema_step = 20'(p >>> 16);
		end
	endfunction
endpackage

/* rtl/rmet_if.sv */
// rmet_if: valid/ready channel carrying one word
// no dependencies
`timescale 1ns / 1ps
interface rmet_if #(parameter int W = 8);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/rmet_ctrl.sv */
// rmet_ctrl: sequencing state machine of the tracker
// depends on rmet_pkg
`timescale 1ns / 1ps
module rmet_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  rmet_pkg::stat_t st,
	output rmet_pkg::cmd_t cmd
);
	import rmet_pkg::*;
	state_t state_q, nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= nxt;
	end

	always_comb begin
		nxt = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					nxt = S_WRITE;
				end
			end
			S_WRITE: begin
				if (st.is_clear) begin
					cmd.clear = 1'b1;
					nxt = S_SNAP;
				end else if (st.is_peak) begin
					cmd.peak_reset = st.seeded;
					nxt = S_SNAP;
				end else if (st.is_sample_match) begin
					cmd.win_write = 1'b1;
					nxt = S_SORT;
				end else nxt = S_SNAP;
			end
			S_SORT: begin
				cmd.sort_step = 1'b1;
				if (st.sort_done) nxt = S_MEDIAN;
			end
			S_MEDIAN: begin
				cmd.med = 1'b1;
				nxt = S_FAST;
			end
			S_FAST: begin
				if (!st.seeded) begin
					cmd.seed = 1'b1;
					nxt = S_SNAP;
				end else begin
					cmd.upd_fast = 1'b1;
					nxt = S_SLOW;
				end
			end
			S_SLOW: begin
				cmd.upd_slow = 1'b1;
				nxt = S_JIT;
			end
			S_JIT: begin
				cmd.upd_jit = 1'b1;
				nxt = S_JIT2;
			end
			S_JIT2: begin
				cmd.fin_jit = 1'b1;
				nxt = S_SNAP;
			end
			S_SNAP: begin
				cmd.snap = 1'b1;
				nxt = S_SNAP2;
			end
			S_SNAP2: begin
				cmd.snap2 = 1'b1;
				nxt = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) nxt = S_IDLE;
			end
			default: nxt = S_IDLE;
		endcase
	end
endmodule

/* rtl/rmet_dp.sv */
// rmet_dp: window, averages and snapshot arithmetic
// depends on rmet_pkg
`timescale 1ns / 1ps
module rmet_dp #(
	parameter int WINDOW_SIZE = rmet_pkg::WINDOW_SIZE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  rmet_pkg::cmd_t cmd,
	output rmet_pkg::stat_t st,
	input  rmet_pkg::cfg_t cfg,
	input  logic [47:0] tracked_address,
	input  logic [1:0] kind,
	input  logic [47:0] adv_address,
	input  logic signed [7:0] rssi,
	input  logic [31:0] now_ms,
	output logic accepted,
	output logic signed [7:0] raw_level,
	output logic signed [15:0] stable_level,
	output logic signed [15:0] best_level,
	output logic signed [16:0] trend_value,
	output logic [15:0] jitter_level,
	output logic [31:0] sample_count,
	output logic [2:0] status,
	output logic [6:0] confidence,
	output logic [9:0] bar_fill
);
	import rmet_pkg::*;
	localparam int PW = $clog2(WINDOW_SIZE + 1);
	localparam int IW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int SW = $clog2(WINDOW_SIZE + 2);

	logic signed [7:0] win_q [WINDOW_SIZE];
	logic signed [7:0] srt_q [WINDOW_SIZE];
	logic [PW-1:0] cnt_q;
	logic [IW-1:0] pos_q;
	logic [SW-1:0] pass_q;
	logic [1:0] kind_q;
	logic match_q;
	logic signed [7:0] rssi_q, raw_q;
	logic [31:0] now_q, last_q, count_q;
	logic signed [15:0] fast_q, slow_q, peak_q, med_q;
	logic signed [16:0] trend_q;
	logic [15:0] jit_q;
	logic [16:0] dev_q;
	logic seeded_q, acc_q;
	logic [31:0] age_s1;
	logic [2:0] status_q;
	logic [6:0] conf_q;
	logic [9:0] fill_q;
	logic [24:0] fillp_s1;

	assign st.is_sample_match = match_q;
	assign st.is_peak = (kind_q == KIND_PEAK);
	assign st.is_clear = (kind_q == KIND_CLEAR);
	assign st.seeded = seeded_q;
	assign st.sort_done = (pass_q == SW'(WINDOW_SIZE));

	// odd-even transposition: pass parity picks pairs
	logic signed [7:0] srt_n [WINDOW_SIZE];
	always_comb begin
		for (int i = 0; i < WINDOW_SIZE; i++) srt_n[i] = srt_q[i];
		for (int i = 0; i + 1 < WINDOW_SIZE; i++) begin
			if ((i % 2) == int'(pass_q[0]) && srt_q[i] > srt_q[i+1] &&
					(i + 1) < int'(cnt_q)) begin
				srt_n[i] = srt_q[i+1];
				srt_n[i+1] = srt_q[i];
			end
		end
	end

	logic signed [15:0] med_n;
	logic [PW-1:0] h;
	always_comb begin
		h = cnt_q >> 1;
		if (cnt_q[0]) med_n = 16'(srt_q[IW'(h)]) <<< 8;
		else med_n = (16'(srt_q[IW'(h - 1'b1)]) + 16'(srt_q[IW'(h)])) <<< 7;
	end

	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		if (v > 20'sd32767) sat16 = 16'sd32767;
		else if (v < -20'sd32768) sat16 = -16'sd32768;
		else sat16 = v[15:0];
	endfunction

	logic signed [19:0] f_n, s_n, j_n;
	logic signed [16:0] dev_n;
	always_comb begin
		f_n = 20'(fast_q) + ema_step(18'(med_q) - 18'(fast_q), cfg.alpha_fast);
		s_n = 20'(slow_q) + ema_step(18'(med_q) - 18'(slow_q), cfg.alpha_slow);
		dev_n = 17'(rssi_q) * 17'sd256 - 17'(fast_q);
		j_n = 20'($signed({4'b0, jit_q})) +
			ema_step(18'($signed({1'b0, dev_q})) - 18'($signed({2'b0, jit_q})),
				cfg.alpha_jit);
	end

	// snapshot: stage one bar bound, stage two score and fill
	logic signed [9:0] score;
	logic [31:0] over;
	logic [27:0] penp;
	logic [7:0] pen;
	logic signed [10:0] net;
	logic [32:0] fillm;
	logic [14:0] bnd_n;
	always_comb begin
		score = 10'(($signed({1'b0, (count_q < 32'd25) ? count_q[4:0] : 5'd25}) * 3));
		if (jit_q[15:6] < 10'd20) score = score + 10'sd20 - $signed({5'd0, jit_q[10:6]});
		// age penalty /75 by reciprocal, exact below 9600; past that the score is gone
		over = age_s1 - 32'd500;
		penp = 28'(over[13:0]) * 28'd13982;
		if (age_s1 <= 32'd500) pen = '0;
		else if (over >= 32'd9600) pen = 8'd128;
		else pen = 8'(penp >> 20);
		net = 11'(score) - $signed({3'd0, pen});
		// /16640 as /256 then /65 by reciprocal
		fillm = 33'(fillp_s1[24:8]) * 33'd64528;
		if (slow_q < -16'sd25600) bnd_n = '0;
		else if (slow_q > -16'sd8960) bnd_n = 15'd16640;
		else bnd_n = 15'(slow_q + 16'sd25600);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pos_q <= '0;
			seeded_q <= 1'b0;
			count_q <= '0;
			last_q <= '0;
			raw_q <= RAW_FLOOR;
			fast_q <= LEVEL_FLOOR;
			slow_q <= LEVEL_FLOOR;
			peak_q <= LEVEL_FLOOR;
			trend_q <= '0;
			jit_q <= '0;
			for (int i = 0; i < WINDOW_SIZE; i++) win_q[i] <= RAW_FLOOR;
		end else begin
			if (cmd.clear) begin
				cnt_q <= '0;
				pos_q <= '0;
				seeded_q <= 1'b0;
				count_q <= '0;
				last_q <= '0;
				raw_q <= RAW_FLOOR;
				fast_q <= LEVEL_FLOOR;
				slow_q <= LEVEL_FLOOR;
				peak_q <= LEVEL_FLOOR;
				trend_q <= '0;
				jit_q <= '0;
				for (int i = 0; i < WINDOW_SIZE; i++) win_q[i] <= RAW_FLOOR;
			end
			if (cmd.win_write) begin
				win_q[pos_q] <= rssi_q;
				pos_q <= (pos_q == IW'(WINDOW_SIZE - 1)) ? '0 : pos_q + 1'b1;
				if (cnt_q < PW'(WINDOW_SIZE)) cnt_q <= cnt_q + 1'b1;
				raw_q <= rssi_q;
				last_q <= now_q;
			end
			if (cmd.peak_reset) begin
				peak_q <= slow_q;
				fast_q <= slow_q;
				trend_q <= '0;
			end
			if (cmd.seed) begin
				fast_q <= med_q;
				slow_q <= med_q;
				peak_q <= med_q;
				trend_q <= '0;
				jit_q <= '0;
				count_q <= 32'd1;
				seeded_q <= 1'b1;
			end
			if (cmd.upd_fast) fast_q <= sat16(f_n);
			if (cmd.upd_slow) begin
				slow_q <= sat16(s_n);
				trend_q <= 17'(fast_q) - 17'(sat16(s_n));
				dev_q <= dev_n[16] ? 17'(-dev_n) : 17'(dev_n);
			end
			if (cmd.upd_jit) begin
				if (j_n < 0) jit_q <= '0;
				else if (j_n > 20'sd65535) jit_q <= 16'hffff;
				else jit_q <= j_n[15:0];
			end
			if (cmd.fin_jit) begin
				if (slow_q > peak_q) peak_q <= slow_q;
				if (count_q != 32'hffffffff) count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q <= kind;
			match_q <= (kind == KIND_SAMPLE) && (adv_address == tracked_address);
			acc_q <= (kind == KIND_SAMPLE) && (adv_address == tracked_address);
			rssi_q <= rssi;
			now_q <= now_ms;
			pass_q <= '0;
		end
		if (cmd.win_write) begin
			// reload sort buffer with the window as it will be
			for (int i = 0; i < WINDOW_SIZE; i++)
				srt_q[i] <= (IW'(i) == pos_q) ? rssi_q : win_q[i];
		end
		if (cmd.sort_step) begin
			srt_q <= srt_n;
			pass_q <= pass_q + 1'b1;
		end
		if (cmd.med) med_q <= med_n;
		if (cmd.snap) begin
			age_s1 <= now_q - last_q;
			fillp_s1 <= 25'(bnd_n) * 25'(cfg.bar_width);
		end
		if (cmd.snap2) begin
			if (!seeded_q) status_q <= ST_SEARCHING;
			else if (age_s1 > cfg.lost_timeout) status_q <= ST_LOST;
			else if (trend_q >= $signed({2'b0, cfg.threshold})) status_q <= ST_WARMER;
			else if (trend_q <= -$signed({2'b0, cfg.threshold})) status_q <= ST_COLDER;
			else status_q <= ST_STEADY;
			if (!seeded_q || net < 0) conf_q <= '0;
			else if (net > 11'sd100) conf_q <= 7'd100;
			else conf_q <= 7'(net);
			fill_q <= 10'(fillm >> 22);
		end
	end

	assign accepted = acc_q;
	assign raw_level = raw_q;
	assign stable_level = slow_q;
	assign best_level = peak_q;
	assign trend_value = trend_q;
	assign jitter_level = jit_q;
	assign sample_count = count_q;
	assign status = status_q;
	assign confidence = conf_q;
	assign bar_fill = fill_q;
endmodule

/* rtl/rssi_median_ema_tracker_unit.sv */
// channel | dir | payload
// in      | sink   | kind, adv_address, rssi, now_ms
// out     | source | accepted .. bar_fill
// cfg     | apb    | 7 registers at 8*i
// a matching sample runs the window sort, one compare pass per cycle for
// WINDOW_SIZE+1 passes, then three average updates (the seeding one seeds
// them instead); other kinds skip the sort. one word is in flight at a time.
// a stalled result holds the unit in its output state with input not ready.
// arst_n clears the window, levels and counters and loads register defaults.
// depends on rmet_pkg, rmet_if, rmet_ctrl, rmet_dp
`timescale 1ns / 1ps
module rssi_median_ema_tracker_unit #(
	parameter int WINDOW_SIZE = rmet_pkg::WINDOW_SIZE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rmet_if.sink   in_ch,
	rmet_if.source out_ch,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [5:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	import rmet_pkg::*;
	logic [47:0] addr_q;
	cfg_t cfg_q;
	cmd_t cmd;
	stat_t st;
	reg_idx_t ridx;

	assign pready = 1'b1;
	assign ridx = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			cfg_q.lost_timeout <= 32'd3000;
			cfg_q.threshold <= 15'd768;
			cfg_q.alpha_fast <= 16'd29491;
			cfg_q.alpha_slow <= 16'd9175;
			cfg_q.alpha_jit <= 16'd11796;
			cfg_q.bar_width <= 10'd200;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_ADDR:   addr_q <= pwdata[47:0];
				REG_LOST:   cfg_q.lost_timeout <= {16'd0, pwdata[15:0]};
				REG_THRESH: cfg_q.threshold <= pwdata[14:0];
				REG_FAST:   cfg_q.alpha_fast <= pwdata[15:0];
				REG_STABLE: cfg_q.alpha_slow <= pwdata[15:0];
				REG_JITTER: cfg_q.alpha_jit <= pwdata[15:0];
				REG_BAR:    cfg_q.bar_width <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_ADDR:   prdata = {16'd0, addr_q};
			REG_LOST:   prdata = {32'd0, cfg_q.lost_timeout};
			REG_THRESH: prdata = {49'd0, cfg_q.threshold};
			REG_FAST:   prdata = {48'd0, cfg_q.alpha_fast};
			REG_STABLE: prdata = {48'd0, cfg_q.alpha_slow};
			REG_JITTER: prdata = {48'd0, cfg_q.alpha_jit};
			REG_BAR:    prdata = {54'd0, cfg_q.bar_width};
			default:    prdata = '0;
		endcase
	end

	rmet_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.st(st), .cmd(cmd)
	);

	rmet_dp #(.WINDOW_SIZE(WINDOW_SIZE)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st), .cfg(cfg_q),
		.tracked_address(addr_q),
		.kind(in_ch.data[89:88]), .adv_address(in_ch.data[87:40]),
		.rssi(in_ch.data[39:32]), .now_ms(in_ch.data[31:0]),
		.accepted(out_ch.data[125]), .raw_level(out_ch.data[124:117]),
		.stable_level(out_ch.data[116:101]), .best_level(out_ch.data[100:85]),
		.trend_value(out_ch.data[84:68]), .jitter_level(out_ch.data[67:52]),
		.sample_count(out_ch.data[51:20]), .status(out_ch.data[19:17]),
		.confidence(out_ch.data[16:10]), .bar_fill(out_ch.data[9:0])
	);
endmodule

/* tb/testbench.sv */
// testbench for rssi_median_ema_tracker_unit: random and directed words checked
// against a scoreboard that predicts each snapshot; depends on rmet_pkg, rmet_if
`timescale 1ns / 1ps
module testbench;
	import rmet_pkg::*;

	typedef struct packed {
		kind_t              kind;
		logic [47:0]        adv;
		logic signed [7:0]  rssi;
		logic [31:0]        now_ms;
	} item_t;

	typedef struct packed {
		logic               accepted;
		logic signed [7:0]  raw;
		logic signed [15:0] stable;
		logic signed [15:0] best;
		logic signed [16:0] trend;
		logic [15:0]        jitter;
		logic [31:0]        count;
		status_t            status;
		logic [6:0]         conf;
		logic [9:0]         fill;
	} snap_t;

	class tracker_scoreboard;
		snap_t snapq[$];
		int errors;
		// registers
		logic [47:0] trk_addr;
		int unsigned lost_ms, thresh, a_fast, a_slow, a_jit, bar_w;
		// tracker state
		int win[7];
		int wcnt, wpos, raw, fast, slow, peak, trend, jit;
		int unsigned cnt, last;
		bit seeded;

		function new();
			trk_addr = 0; lost_ms = 3000; thresh = 768;
			a_fast = 29491; a_slow = 9175; a_jit = 11796; bar_w = 200;
			clear_tracker();
		endfunction

		function void clear_tracker();
			foreach (win[i]) win[i] = -127;
			wcnt = 0; wpos = 0; raw = -127;
			fast = -32512; slow = -32512; peak = -32512;
			trend = 0; jit = 0; cnt = 0; last = 0; seeded = 0;
		endfunction

		function void set_reg(reg_idx_t idx, longint unsigned v);
			case (idx)
				REG_ADDR:   trk_addr = v[47:0];
				REG_LOST:   lost_ms = v[15:0];
				REG_THRESH: thresh = v[14:0];
				REG_FAST:   a_fast = v[15:0];
				REG_STABLE: a_slow = v[15:0];
				REG_JITTER: a_jit = v[15:0];
				REG_BAR:    bar_w = v[9:0];
				default: ;
			endcase
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		// floor((alpha*d + half) / 2^16)
		function longint ema_delta(longint d, longint a);
			longint v;
			v = a * d + 32768;
			return v >>> 16;
		endfunction

		function int window_median();
			int srt[7];
			int j, v;
			for (int i = 0; i < wcnt; i++) begin
				v = win[i];
				j = i;
				while (j > 0 && srt[j-1] > v) begin
					srt[j] = srt[j-1];
					j--;
				end
				srt[j] = v;
			end
			if (wcnt % 2) return srt[wcnt/2] * 256;
			return (srt[wcnt/2-1] + srt[wcnt/2]) * 128;
		endfunction

		function void push_sample(int r, int unsigned now);
			int m, dev;
			win[wpos] = r;
			wpos = (wpos + 1) % 7;
			if (wcnt < 7) wcnt++;
			m = window_median();
			raw = r;
			last = now;
			if (!seeded) begin
				fast = m; slow = m; peak = m;
				trend = 0; jit = 0; cnt = 1; seeded = 1;
				return;
			end
			fast = clip(fast + ema_delta(m - fast, a_fast), -32768, 32767);
			slow = clip(slow + ema_delta(m - slow, a_slow), -32768, 32767);
			trend = fast - slow;
			dev = r * 256 - fast;
			if (dev < 0) dev = -dev;
			jit = clip(jit + ema_delta(dev - jit, a_jit), 0, 65535);
			if (slow > peak) peak = slow;
			if (cnt != 32'hFFFF_FFFF) cnt++;
		endfunction

		function void note(item_t it);
			snap_t s;
			int unsigned age;
			longint score, stab, b;
			s = '0;
			case (it.kind)
				KIND_SAMPLE: if (it.adv == trk_addr) begin
					push_sample(it.rssi, it.now_ms);
					s.accepted = 1;
				end
				KIND_PEAK: if (seeded) begin
					peak = slow; fast = slow; trend = 0;
				end
				KIND_CLEAR: clear_tracker();
				default: ;
			endcase
			age = it.now_ms - last;
			if (!seeded) s.status = ST_SEARCHING;
			else if (age > lost_ms) s.status = ST_LOST;
			else if (trend >= int'(thresh)) s.status = ST_WARMER;
			else if (trend <= -int'(thresh)) s.status = ST_COLDER;
			else s.status = ST_STEADY;
			if (seeded) begin
				stab = 20 - (jit >> 6);
				if (stab < 0) stab = 0;
				score = (cnt < 25 ? cnt : 25) * 3 + stab;
				if (age > 500) score -= (age - 500) / 75;
				s.conf = clip(score, 0, 100);
			end
			b = clip(slow, -25600, -8960);
			s.fill = ((b + 25600) * bar_w) / 16640;
			s.raw = raw; s.stable = slow; s.best = peak; s.trend = trend;
			s.jitter = jit; s.count = cnt;
			snapq.insert(snapq.size(), s);
		endfunction

		function void cmp(string name, longint e, longint a);
			if (e == a) return;
			errors++;
			if (errors <= 10)
				$display("mismatch %s: expected %0d actual %0d", name, e, a);
		endfunction

		function void check(snap_t a);
			snap_t e;
			if (snapq.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected output word %h", a);
				return;
			end
			e = snapq.pop_front();
			cmp("accepted", e.accepted, a.accepted);
			cmp("raw_level", e.raw, a.raw);
			cmp("stable_level", e.stable, a.stable);
			cmp("best_level", e.best, a.best);
			cmp("trend_value", e.trend, a.trend);
			cmp("jitter_level", e.jitter, a.jitter);
			cmp("sample_count", e.count, a.count);
			cmp("status", e.status, a.status);
			cmp("confidence", e.conf, a.conf);
			cmp("bar_fill", e.fill, a.fill);
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [5:0] paddr;
	logic [63:0] pwdata, prdata;
	rmet_if #(.W($bits(item_t))) in_ch();
	rmet_if #(.W($bits(snap_t))) out_ch();

	rssi_median_ema_tracker_unit DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	tracker_scoreboard sb = new();
	bit idle_on = 1;
	int unsigned cycles = 0;
	int unsigned tnow = 0;
	int stall = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: check accepted words, then stall in random bursts
	initial begin
		out_ch.ready = 0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) sb.check(out_ch.data);
			if (stall > 0) begin
				stall--;
				out_ch.ready <= 0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(0, 3);
				out_ch.ready <= 0;
			end else begin
				out_ch.ready <= 1;
			end
		end
	end

	task automatic send(item_t it);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		sb.note(it);
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (sb.snapq.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, longint unsigned v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= 6'(idx * 8); pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		sb.set_reg(idx, v);
	endtask

	function automatic longint unsigned pick(longint unsigned hi);
		case ($urandom_range(0, 3))
			0: return 0;
			1: return hi;
			default: return {$urandom, $urandom} % (hi + 1);
		endcase
	endfunction

	task automatic sample(logic [47:0] a, int r, int unsigned dt);
		item_t it;
		tnow += dt;
		it.kind = KIND_SAMPLE; it.adv = a; it.rssi = r; it.now_ms = tnow;
		send(it);
	endtask

	task automatic other(kind_t k, int unsigned dt);
		item_t it;
		tnow += dt;
		it.kind = k; it.adv = {$urandom, $urandom}; it.rssi = $urandom;
		it.now_ms = tnow;
		send(it);
	endtask

	task automatic random_item();
		item_t it;
		int base;
		int unsigned p;
		p = $urandom_range(0, 99);
		case ($urandom_range(0, 19))
			0: tnow += $urandom_range(500, 70000);
			1: tnow = $urandom;
			default: tnow += $urandom_range(0, 150);
		endcase
		it.now_ms = tnow;
		it.rssi = $urandom;
		it.adv = sb.trk_addr;
		if (p < 70) begin
			it.kind = KIND_SAMPLE;
			base = -40 - int'(($urandom_range(0, 60) + tnow / 50) % 60);
			if ($urandom_range(0, 2) != 0)
				it.rssi = base + $urandom_range(0, 8) - 4;
		end else if (p < 78) begin
			it.kind = KIND_SAMPLE;
			if ($urandom_range(0, 1)) it.adv = {$urandom, $urandom};
			else it.adv[$urandom_range(0, 47)] ^= 1'b1;
		end else if (p < 88) begin
			it.kind = KIND_PEAK;
			it.adv = {$urandom, $urandom};
		end else if (p < 98) begin
			it.kind = KIND_QUERY;
			it.adv = {$urandom, $urandom};
		end else begin
			it.kind = KIND_CLEAR;
			it.adv = {$urandom, $urandom};
		end
		send(it);
	endtask

	initial begin
		logic [47:0] a;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_ch.valid = 0; in_ch.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		// directed: unseeded kinds, seeding, extremes, mismatch, clear
		a = 48'hA5C3_0F1E_7B29;
		write_reg(REG_ADDR, a);
		other(KIND_QUERY, 10);
		other(KIND_PEAK, 10);
		sample(a ^ 48'h1, -50, 5);
		sample(a, -60, 5);
		sample(a, 127, 5);
		sample(a, -128, 5);
		sample(a, -70, 5);
		sample(a, -65, 600);
		other(KIND_QUERY, 4000);
		other(KIND_PEAK, 5);
		sample(a, -40, 5);
		sample(a, -38, 5);
		sample(a, -36, 5);
		sample(a, -30, 5);
		other(KIND_QUERY, 5);
		other(KIND_CLEAR, 5);
		other(KIND_QUERY, 5);
		sample(a, -90, 5);
		tnow = 32'hFFFF_FFF0;
		sample(a, -80, 0);
		other(KIND_QUERY, 40);
		drain();
		write_reg(REG_THRESH, 0);
		sample(a, -80, 5);
		sample(a, -80, 5);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			if (ph == 6) idle_on = 0;
			case (ph)
				0: a = 48'h0;
				1: a = 48'hFFFF_FFFF_FFFF;
				default: a = {$urandom, $urandom};
			endcase
			write_reg(REG_ADDR, a);
			write_reg(REG_LOST, pick(16'hFFFF) | (ph == 2 ? 0 : 64'd200));
			write_reg(REG_THRESH, ph == 1 ? 15'h7FFF : pick(15'h7FFF) % 2048);
			write_reg(REG_FAST, ph == 2 ? 16'hFFFF : pick(16'hFFFF));
			write_reg(REG_STABLE, ph == 3 ? 0 : pick(16'hFFFF));
			write_reg(REG_JITTER, pick(16'hFFFF));
			write_reg(REG_BAR, pick(10'h3FF));
			if (ph == 4) begin
				write_reg(REG_FAST, 29491);
				write_reg(REG_STABLE, 9175);
				write_reg(REG_JITTER, 11796);
			end
			other(KIND_CLEAR, 1);
			repeat (260) random_item();
			drain();
		end

		if (sb.errors == 0 && sb.snapq.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
